FILE: hw/rtl/multi_stack_partitioned_memory_macros.svh
// ----------------------------------------------------------------------------
// multi stack memory assertion macros
// shared property shorthands, clocked on clk and disabled during rst
// ----------------------------------------------------------------------------
`ifndef MULTI_STACK_PARTITIONED_MEMORY_MACROS_SVH
`define MULTI_STACK_PARTITIONED_MEMORY_MACROS_SVH

// same-cycle implication
`define MSP_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("msp assertion failed");

// next-cycle implication
`define MSP_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("msp assertion failed");

`endif

FILE: hw/rtl/msp_pkg.sv
// ----------------------------------------------------------------------------
// msp_pkg
// types and fixed field widths of the multi stack memory
// ----------------------------------------------------------------------------
package msp_pkg;

  localparam int OP_W   = 2;
  localparam int SEL_W  = 3;
  localparam int DATA_W = 32;
  localparam int CFG_W  = 4;
  localparam int NUM_STACKS_RESET = 4;

  typedef enum logic [OP_W-1:0] {
    OP_PUSH    = 2'd0,
    OP_POP     = 2'd1,
    OP_DISPLAY = 2'd2
  } op_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_EMPTY     = 2'd2,
    ST_BAD_STACK = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_POP,
    S_DISP
  } state_t;

endpackage

FILE: hw/rtl/multi_stack_partitioned_memory.sv
// ----------------------------------------------------------------------------
// multi_stack_partitioned_memory
// several lifo stacks in equal segments of one shared memory
// ----------------------------------------------------------------------------
//  channel  signals                              direction
//  cfg      cfg_wr_en, cfg_wr_data               in, write only
//  in       in_valid/in_ready, op, stack_sel,    in
//           value
//  out      out_valid/out_ready, status, data,   out
//           last
//
//  push, bad stack, full and empty are captured, then executed.
//  pop adds a wait for the registered memory read.
//  display returns one beat per stored entry, one beat a cycle while out_ready is high.
//  rst is synchronous and empties every stack; memory contents stay as they were.
//  out_ready low holds the result and stalls the sequencer until taken.
// ----------------------------------------------------------------------------
module multi_stack_partitioned_memory
  import msp_pkg::*;
#(
  parameter int MEM_DEPTH  = 32,
  parameter int MAX_STACKS = 8
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     cfg_wr_en,
  input  logic [CFG_W-1:0]         cfg_wr_data,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [OP_W-1:0]          op,
  input  logic [SEL_W-1:0]         stack_sel,
  input  logic signed [DATA_W-1:0] value,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic [1:0]               status,
  output logic signed [DATA_W-1:0] data,
  output logic                     last
);

`include "multi_stack_partitioned_memory_macros.svh"

  localparam int AW      = $clog2(MEM_DEPTH);
  localparam int CW      = $clog2(MEM_DEPTH + 1);
  localparam int SW      = (MAX_STACKS > 1) ? $clog2(MAX_STACKS) : 1;
  localparam int NW      = $clog2(MAX_STACKS + 1);
  localparam int WIDE    = CW + SEL_W;
  localparam int NUM_RST = (NUM_STACKS_RESET > MAX_STACKS) ? MAX_STACKS : NUM_STACKS_RESET;
  localparam int SEG_RST = MEM_DEPTH / NUM_RST;

  state_t state, state_next;

  logic [NW-1:0] num_stacks;
  logic [CW-1:0] seg_words;
  logic [CW-1:0] fill_count [MAX_STACKS];
  logic [CW-1:0] seg_tab [MAX_STACKS];
  logic [NW-1:0] n_new;

  logic [OP_W-1:0]   op_r;
  logic [SEL_W-1:0]  sel_r;
  logic [DATA_W-1:0] value_r;

  logic [SW-1:0]   sidx;
  logic            bad;
  logic [CW-1:0]   cnt;
  logic            full;
  logic [WIDE-1:0] base_w;
  logic [AW-1:0]   push_addr, pop_addr, base_addr;

  logic              wr_en, rd_en;
  logic [AW-1:0]     rd_addr;
  logic [DATA_W-1:0] rd_data;

  logic          cnt_we;
  logic [CW-1:0] cnt_val;
  logic [AW-1:0] disp_ptr, disp_ptr_next;
  logic [CW-1:0] disp_left, disp_left_next;

  logic              out_free, out_load;
  status_t           out_status, out_status_next;
  logic [DATA_W-1:0] out_data, out_data_next;
  logic              out_last, out_last_next;

  // segment size for each stack count, fixed at elaboration
  for (genvar g = 0; g < MAX_STACKS; g++) begin : g_seg
    localparam int SEG = MEM_DEPTH / (g + 1);
    assign seg_tab[g] = CW'(SEG);
  end

  always_comb begin
    if (cfg_wr_data == '0) begin
      n_new = NW'(1);
    end else if (32'(cfg_wr_data) > MAX_STACKS) begin
      n_new = NW'(MAX_STACKS);
    end else begin
      n_new = NW'(cfg_wr_data);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      num_stacks <= NW'(NUM_RST);
      seg_words  <= CW'(SEG_RST);
    end else if (cfg_wr_en) begin
      num_stacks <= n_new;
      seg_words  <= seg_tab[SW'(n_new - 1'b1)];
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cfg_wr_en) begin
      for (int i = 0; i < MAX_STACKS; i++) begin
        fill_count[i] <= '0;
      end
    end else if (cnt_we) begin
      fill_count[sidx] <= cnt_val;
    end
  end

  assign in_ready = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      op_r    <= op;
      sel_r   <= stack_sel;
      value_r <= value;
    end
  end

  // decode of the captured beat
  assign sidx      = SW'(sel_r);
  assign bad       = 32'(sel_r) >= 32'(num_stacks);
  assign cnt       = bad ? '0 : fill_count[sidx];
  assign full      = cnt >= seg_words;
  assign base_w    = WIDE'(seg_words) * WIDE'(sel_r);
  assign base_addr = AW'(base_w);
  assign push_addr = AW'(base_w + WIDE'(cnt));
  assign pop_addr  = AW'(base_w + WIDE'(cnt) - 1'b1);

  assign out_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next      = state;
    wr_en           = 1'b0;
    rd_en           = 1'b0;
    rd_addr         = disp_ptr;
    cnt_we          = 1'b0;
    cnt_val         = cnt;
    disp_ptr_next   = disp_ptr;
    disp_left_next  = disp_left;
    out_load        = 1'b0;
    out_status_next = ST_OK;
    out_data_next   = '0;
    out_last_next   = 1'b1;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        if (op_r != OP_PUSH && op_r != OP_POP && op_r != OP_DISPLAY) begin
          // unused op code, no result
          state_next = S_IDLE;
        end else if (out_free) begin
          state_next = S_IDLE;
          if (bad) begin
            out_load        = 1'b1;
            out_status_next = ST_BAD_STACK;
          end else begin
            unique case (op_r)
              OP_PUSH: begin
                out_load = 1'b1;
                if (full) begin
                  out_status_next = ST_FULL;
                end else begin
                  wr_en   = 1'b1;
                  cnt_we  = 1'b1;
                  cnt_val = cnt + 1'b1;
                end
              end
              OP_POP, OP_DISPLAY: begin
                if (cnt == '0) begin
                  out_load        = 1'b1;
                  out_status_next = ST_EMPTY;
                end else if (op_r == OP_POP) begin
                  rd_en      = 1'b1;
                  rd_addr    = pop_addr;
                  cnt_we     = 1'b1;
                  cnt_val    = cnt - 1'b1;
                  state_next = S_POP;
                end else begin
                  rd_en          = 1'b1;
                  rd_addr        = base_addr;
                  disp_ptr_next  = base_addr + 1'b1;
                  disp_left_next = cnt;
                  state_next     = S_DISP;
                end
              end
              default: begin
                state_next = S_IDLE;
              end
            endcase
          end
        end
      end
      S_POP: begin
        if (out_free) begin
          out_load      = 1'b1;
          out_data_next = rd_data;
          state_next    = S_IDLE;
        end
      end
      S_DISP: begin
        if (out_free) begin
          out_load      = 1'b1;
          out_data_next = rd_data;
          out_last_next = (disp_left == CW'(1));
          if (disp_left == CW'(1)) begin
            state_next = S_IDLE;
          end else begin
            // fetch the next entry up while this one goes out
            rd_en          = 1'b1;
            disp_ptr_next  = disp_ptr + 1'b1;
            disp_left_next = disp_left - 1'b1;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    disp_ptr  <= disp_ptr_next;
    disp_left <= disp_left_next;
  end

  msp_stack_ram #(
    .DEPTH (MEM_DEPTH),
    .AW    (AW)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (push_addr),
    .wr_data (value_r),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_status <= out_status_next;
      out_data   <= out_data_next;
      out_last   <= out_last_next;
    end
  end

  assign status = out_status;
  assign data   = out_data;
  assign last   = out_last;

  `MSP_ASSERT_NOW(a_no_overwrite, out_load, !out_valid || out_ready)
  `MSP_ASSERT_NOW(a_count_in_segment, cnt_we, cnt_val <= seg_words)
  `MSP_ASSERT_NEXT(a_last_ends_item, out_load && out_last_next, state == S_IDLE)
  `MSP_ASSERT_NEXT(a_accept_executes, in_valid && in_ready, state == S_EXEC)

endmodule

FILE: hw/rtl/msp_stack_ram.sv
// ----------------------------------------------------------------------------
// msp_stack_ram
// shared stack storage, one write and one read port, registered read data
// ----------------------------------------------------------------------------
module msp_stack_ram
  import msp_pkg::*;
#(
  parameter int DEPTH = 32,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [AW-1:0]     wr_addr,
  input  logic [DATA_W-1:0] wr_data,
  input  logic              rd_en,
  input  logic [AW-1:0]     rd_addr,
  output logic [DATA_W-1:0] rd_data
);

  logic [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // read data holds until the next read
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule
